### rtl/cartesian_to_polar_assert.svh
// assertion macros for the cartesian to polar converter
`ifndef CARTESIAN_TO_POLAR_ASSERT_SVH
`define CARTESIAN_TO_POLAR_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define C2P_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cartesian_to_polar check failed");

// next-cycle implication
`define C2P_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cartesian_to_polar check failed");

`endif

### rtl/c2p_pkg.sv
// shared constants, control word type and arctangent table of the polar converter
package c2p_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int STAGES_DEF      = 16;
   localparam int GUARD           = 16;
   localparam int ACC_WIDTH       = 32;

   localparam logic [ACC_WIDTH-1:0] TURN_ZERO     = 32'h0000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_QUARTER  = 32'h4000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_HALF     = 32'h8000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_3QUARTER = 32'hC000_0000;

   typedef struct packed {
      logic valid;
      logic fixed;
   } ctrl_type;

   // atan(2^-idx) as a fraction of a full turn, 2^32 per turn
   function automatic logic [ACC_WIDTH-1:0] atan_turns(input int idx);
      logic [ACC_WIDTH-1:0] value;
      case (idx)
         0:  value = 32'd536870912;
         1:  value = 32'd316933406;
         2:  value = 32'd167458907;
         3:  value = 32'd85004756;
         4:  value = 32'd42667331;
         5:  value = 32'd21354465;
         6:  value = 32'd10679838;
         7:  value = 32'd5340245;
         8:  value = 32'd2670163;
         9:  value = 32'd1335087;
         10: value = 32'd667544;
         11: value = 32'd333772;
         12: value = 32'd166886;
         13: value = 32'd83443;
         14: value = 32'd41722;
         15: value = 32'd20861;
         16: value = 32'd10430;
         17: value = 32'd5215;
         18: value = 32'd2608;
         19: value = 32'd1304;
         20: value = 32'd652;
         21: value = 32'd326;
         22: value = 32'd163;
         23: value = 32'd81;
         24: value = 32'd41;
         25: value = 32'd20;
         26: value = 32'd10;
         27: value = 32'd5;
         28: value = 32'd3;
         29: value = 32'd1;
         30: value = 32'd1;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

### rtl/cartesian_to_polar.sv
// channel  dir  ports                              word
// req      in   req_valid req_ready                x_coord, y_coord (signed)
// rsp      out  rsp_valid rsp_ready                magnitude, angle (unsigned)
//
// one word in and one word out per cycle unless the output stalls; each word passes front
// registers a and b, the one-step-per-stage cordic/root stages and the output register
// reset is synchronous and clears only the control words, there is no clearing pass
// each stage loads when it is empty or its successor loads, so a stalled output fills
// empty stages first and input is refused only once every stage holds a word
module cartesian_to_polar #(
   parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = c2p_pkg::ANGLE_WIDTH_DEF,
   parameter int STAGES      = c2p_pkg::STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_WIDTH-1:0]        rsp_magnitude,
   output logic [ANGLE_WIDTH-1:0]        rsp_angle
);
   import c2p_pkg::*;

   localparam int DATA_WIDTH = COORD_WIDTH + GUARD + 3;
   localparam int DEPTH      = (STAGES > COORD_WIDTH) ? STAGES : COORD_WIDTH;

   ctrl_type                     pipe_ctrl [0:DEPTH];
   logic signed [DATA_WIDTH-1:0] pipe_x    [0:DEPTH];
   logic signed [DATA_WIDTH-1:0] pipe_y    [0:DEPTH];
   logic [ACC_WIDTH-1:0]         pipe_acc  [0:DEPTH];
   logic [2*COORD_WIDTH-1:0]     pipe_rem  [0:DEPTH];
   logic [COORD_WIDTH-1:0]       pipe_root [0:DEPTH];
   logic [DEPTH:0]               pipe_valid;
   logic [DEPTH+1:0]             ld;
   logic                         ld_a;
   logic                         a_valid;

   assign ld[DEPTH+1]  = !rsp_valid || rsp_ready;
   assign ld_a         = !a_valid || ld[0];
   assign req_ready    = ld_a;
   assign pipe_root[0] = '0;

   generate
      for (genvar k = 0; k <= DEPTH; k++) begin : g_ld
         assign pipe_valid[k] = pipe_ctrl[k].valid;
         assign ld[k]         = !pipe_ctrl[k].valid || ld[k+1];
      end
   endgenerate

   c2p_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .ld_a        (ld_a),
      .ld_b        (ld[0]),
      .req_valid   (req_valid),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .a_valid     (a_valid),
      .dns_ctrl    (pipe_ctrl[0]),
      .dns_x       (pipe_x[0]),
      .dns_y       (pipe_y[0]),
      .dns_acc     (pipe_acc[0]),
      .dns_rem     (pipe_rem[0])
   );

   generate
      for (genvar k = 0; k < DEPTH; k++) begin : g_stage
         c2p_stage #(
            .COORD_WIDTH (COORD_WIDTH),
            .DATA_WIDTH  (DATA_WIDTH),
            .STAGES      (STAGES),
            .INDEX       (k)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .ld       (ld[k+1]),
            .ups_ctrl (pipe_ctrl[k]),
            .ups_x    (pipe_x[k]),
            .ups_y    (pipe_y[k]),
            .ups_acc  (pipe_acc[k]),
            .ups_rem  (pipe_rem[k]),
            .ups_root (pipe_root[k]),
            .dns_ctrl (pipe_ctrl[k+1]),
            .dns_x    (pipe_x[k+1]),
            .dns_y    (pipe_y[k+1]),
            .dns_acc  (pipe_acc[k+1]),
            .dns_rem  (pipe_rem[k+1]),
            .dns_root (pipe_root[k+1])
         );
      end
   endgenerate

   c2p_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .ld            (ld[DEPTH+1]),
      .ups_ctrl      (pipe_ctrl[DEPTH]),
      .ups_acc       (pipe_acc[DEPTH]),
      .ups_rem       (pipe_rem[DEPTH]),
      .ups_root      (pipe_root[DEPTH]),
      .rsp_valid     (rsp_valid),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle     (rsp_angle)
   );

   `include "cartesian_to_polar_assert.svh"

   // input is refused only when every stage is full and the output is stalled
   `C2P_CHECK_NOW(full_stall_blocks, rsp_valid && !rsp_ready && a_valid && (&pipe_valid), !req_ready)
   `C2P_CHECK_NEXT(accept_fills_front, req_valid && req_ready, a_valid)
   `C2P_CHECK_NEXT(drain_to_output, pipe_valid[DEPTH] && ld[DEPTH+1], rsp_valid)

endmodule

### rtl/c2p_front.sv
// front end: squares, axis detection, half-turn prerotation, sum of squares
module c2p_front #(
   parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
   parameter int DATA_WIDTH  = c2p_pkg::COORD_WIDTH_DEF + c2p_pkg::GUARD + 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              ld_a,
   input  logic                              ld_b,
   input  logic                              req_valid,
   input  logic signed [COORD_WIDTH-1:0]     req_x_coord,
   input  logic signed [COORD_WIDTH-1:0]     req_y_coord,
   output logic                              a_valid,
   output c2p_pkg::ctrl_type                 dns_ctrl,
   output logic signed [DATA_WIDTH-1:0]      dns_x,
   output logic signed [DATA_WIDTH-1:0]      dns_y,
   output logic [c2p_pkg::ACC_WIDTH-1:0]     dns_acc,
   output logic [2*COORD_WIDTH-1:0]          dns_rem
);
   import c2p_pkg::*;

   logic signed [2*COORD_WIDTH-1:0] sq_x, sq_y;
   logic signed [DATA_WIDTH-1:0]    x_ext, y_ext, x_rot, y_rot;
   logic                            x_zero, y_zero, x_neg, y_neg;
   logic [ACC_WIDTH-1:0]            acc_a_in;
   ctrl_type                        ctrl_a_in;

   ctrl_type                        ctrl_a_ff, ctrl_b_ff;
   logic [2*COORD_WIDTH-1:0]        sq_x_ff, sq_y_ff, rem_b_ff;
   logic signed [DATA_WIDTH-1:0]    x_a_ff, y_a_ff, x_b_ff, y_b_ff;
   logic [ACC_WIDTH-1:0]            acc_a_ff, acc_b_ff;

   assign sq_x = (2*COORD_WIDTH)'(req_x_coord) * (2*COORD_WIDTH)'(req_x_coord);
   assign sq_y = (2*COORD_WIDTH)'(req_y_coord) * (2*COORD_WIDTH)'(req_y_coord);

   always_comb begin
      x_ext  = DATA_WIDTH'(req_x_coord);
      y_ext  = DATA_WIDTH'(req_y_coord);
      x_zero = (req_x_coord == '0);
      y_zero = (req_y_coord == '0);
      x_neg  = req_x_coord[COORD_WIDTH-1];
      y_neg  = req_y_coord[COORD_WIDTH-1];
      ctrl_a_in.valid = req_valid;
      ctrl_a_in.fixed = x_zero || y_zero;
      if (x_zero) begin
         acc_a_in = y_neg ? TURN_3QUARTER : TURN_QUARTER;
      end else begin
         acc_a_in = x_neg ? TURN_HALF : TURN_ZERO;
      end
      x_rot = x_neg ? -x_ext : x_ext;
      y_rot = x_neg ? -y_ext : y_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
         ctrl_b_ff <= '0;
      end else begin
         if (ld_a) begin
            ctrl_a_ff <= ctrl_a_in;
         end
         if (ld_b) begin
            ctrl_b_ff <= ctrl_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_a) begin
         sq_x_ff  <= $unsigned(sq_x);
         sq_y_ff  <= $unsigned(sq_y);
         x_a_ff   <= x_rot <<< GUARD;
         y_a_ff   <= y_rot <<< GUARD;
         acc_a_ff <= acc_a_in;
      end
      if (ld_b) begin
         rem_b_ff <= sq_x_ff + sq_y_ff;
         x_b_ff   <= x_a_ff;
         y_b_ff   <= y_a_ff;
         acc_b_ff <= acc_a_ff;
      end
   end

   assign a_valid  = ctrl_a_ff.valid;
   assign dns_ctrl = ctrl_b_ff;
   assign dns_x    = x_b_ff;
   assign dns_y    = y_b_ff;
   assign dns_acc  = acc_b_ff;
   assign dns_rem  = rem_b_ff;

endmodule

### rtl/c2p_stage.sv
// one pipeline stage: a cordic vectoring step (INDEX < STAGES, word not fixed) and a root bit (INDEX < COORD_WIDTH)
module c2p_stage #(
   parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
   parameter int DATA_WIDTH  = c2p_pkg::COORD_WIDTH_DEF + c2p_pkg::GUARD + 3,
   parameter int STAGES      = c2p_pkg::STAGES_DEF,
   parameter int INDEX       = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              ld,
   input  c2p_pkg::ctrl_type                 ups_ctrl,
   input  logic signed [DATA_WIDTH-1:0]      ups_x,
   input  logic signed [DATA_WIDTH-1:0]      ups_y,
   input  logic [c2p_pkg::ACC_WIDTH-1:0]     ups_acc,
   input  logic [2*COORD_WIDTH-1:0]          ups_rem,
   input  logic [COORD_WIDTH-1:0]            ups_root,
   output c2p_pkg::ctrl_type                 dns_ctrl,
   output logic signed [DATA_WIDTH-1:0]      dns_x,
   output logic signed [DATA_WIDTH-1:0]      dns_y,
   output logic [c2p_pkg::ACC_WIDTH-1:0]     dns_acc,
   output logic [2*COORD_WIDTH-1:0]          dns_rem,
   output logic [COORD_WIDTH-1:0]            dns_root
);
   import c2p_pkg::*;

   localparam bit DO_CORDIC = (INDEX < STAGES);
   localparam bit DO_ROOT   = (INDEX < COORD_WIDTH);
   localparam int SQ_BIT    = DO_ROOT ? (COORD_WIDTH - 1 - INDEX) : 0;
   localparam int TW        = 2 * COORD_WIDTH + 1;
   localparam logic [ACC_WIDTH-1:0] ATAN = atan_turns(INDEX);

   logic signed [DATA_WIDTH-1:0] dx, dy, x_in, y_in;
   logic [ACC_WIDTH-1:0]         acc_in;
   logic [TW-1:0]                trial;
   logic [2*COORD_WIDTH-1:0]     rem_in;
   logic [COORD_WIDTH-1:0]       root_in;

   ctrl_type                     ctrl_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, y_ff;
   logic [ACC_WIDTH-1:0]         acc_ff;
   logic [2*COORD_WIDTH-1:0]     rem_ff;
   logic [COORD_WIDTH-1:0]       root_ff;

   always_comb begin
      dx     = ups_y >>> INDEX;
      dy     = ups_x >>> INDEX;
      x_in   = ups_x;
      y_in   = ups_y;
      acc_in = ups_acc;
      if (DO_CORDIC && !ups_ctrl.fixed) begin
         if (!ups_y[DATA_WIDTH-1]) begin
            x_in   = ups_x + dx;
            y_in   = ups_y - dy;
            acc_in = ups_acc + ATAN;
         end else begin
            x_in   = ups_x - dx;
            y_in   = ups_y + dy;
            acc_in = ups_acc - ATAN;
         end
      end
   end

   // trial (2q + 2^k) * 2^k against the running remainder
   always_comb begin
      trial   = (TW'(ups_root) << (SQ_BIT + 1)) | (TW'(1) << (2 * SQ_BIT));
      rem_in  = ups_rem;
      root_in = ups_root;
      if (DO_ROOT && ({1'b0, ups_rem} >= trial)) begin
         rem_in  = ups_rem - trial[2*COORD_WIDTH-1:0];
         root_in = ups_root | (COORD_WIDTH'(1) << SQ_BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (ld) begin
         ctrl_ff <= ups_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dns_ctrl = ctrl_ff;
   assign dns_x    = x_ff;
   assign dns_y    = y_ff;
   assign dns_acc  = acc_ff;
   assign dns_rem  = rem_ff;
   assign dns_root = root_ff;

endmodule

### rtl/c2p_back.sv
// back end: magnitude rounding, angle rounding when narrower than the accumulator, and the output register
module c2p_back #(
   parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = c2p_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              ld,
   input  c2p_pkg::ctrl_type                 ups_ctrl,
   input  logic [c2p_pkg::ACC_WIDTH-1:0]     ups_acc,
   input  logic [2*COORD_WIDTH-1:0]          ups_rem,
   input  logic [COORD_WIDTH-1:0]            ups_root,
   output logic                              rsp_valid,
   output logic [COORD_WIDTH-1:0]            rsp_magnitude,
   output logic [ANGLE_WIDTH-1:0]            rsp_angle
);
   import c2p_pkg::*;

   logic                   valid_ff;
   logic [COORD_WIDTH-1:0] mag_in, mag_ff;
   logic [ANGLE_WIDTH-1:0] angle_in, angle_ff;

   // remainder above the root means the exact root is past the half point
   assign mag_in = (ups_rem > (2*COORD_WIDTH)'(ups_root)) ?
                   ups_root + COORD_WIDTH'(1) : ups_root;

   generate
      if (ANGLE_WIDTH >= ACC_WIDTH) begin : g_full
         assign angle_in = ANGLE_WIDTH'(ups_acc);
      end else begin : g_round
         logic [ACC_WIDTH:0] acc_rnd;
         assign acc_rnd  = {1'b0, ups_acc} + ((ACC_WIDTH + 1)'(1) << (ACC_WIDTH - 1 - ANGLE_WIDTH));
         assign angle_in = acc_rnd[ACC_WIDTH-1:ACC_WIDTH-ANGLE_WIDTH];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ld) begin
         valid_ff <= ups_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         mag_ff   <= mag_in;
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_angle     = angle_ff;

endmodule

### test/cartesian_to_polar_tb.sv
// self-checking testbench for cartesian_to_polar: scoreboard class, stimulus tasks and checks
module cartesian_to_polar_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import c2p_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int AW = ANGLE_WIDTH_DEF;
   localparam int NUM_STAGES = STAGES_DEF;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PER_PHASE = 310;

   localparam logic [ACC_WIDTH-1:0] ATAN_STEP [NUM_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
      32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
      32'd166886, 32'd83443, 32'd41722, 32'd20861
   };

   localparam logic signed [CW-1:0] CORNERS [7] = '{
      -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767
   };

   localparam logic signed [CW-1:0] DIRECTED_X [23] = '{
      16'sd0, 16'sd0, -16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
      16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd1, -16'sd1, 16'sd1,
      -16'sd1, 16'sd0, 16'sd3, -16'sd3, -16'sd32768, 16'sd1, -16'sd1, 16'sd12345
   };
   localparam logic signed [CW-1:0] DIRECTED_Y [23] = '{
      16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, -16'sd1,
      16'sd1, 16'sd1, 16'sd4, -16'sd4, 16'sd1, -16'sd32768, -16'sd32768, -16'sd23456
   };

   typedef struct {
      logic [CW-1:0] magnitude;
      logic [AW-1:0] angle;
   } polar_word_type;

   class polar_scoreboard;
      polar_word_type expected_q[$];
      int unsigned checked;
      int unsigned mismatches;

      function polar_word_type predict_polar(logic signed [CW-1:0] x_in,
                                             logic signed [CW-1:0] y_in);
         polar_word_type w;
         longint x, y, dx, dy;
         longint unsigned sq, rem, root, bitv;
         logic [ACC_WIDTH-1:0] turn, rounded;
         x = longint'(x_in);
         y = longint'(y_in);
         sq = x * x + y * y;
         rem = sq;
         root = 0;
         bitv = 64'h1 << 62;
         while (bitv > rem) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (rem >= root + bitv) begin
               rem = rem - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         // no ties: round to nearest by comparing the remainder
         if (sq - root * root > root) root = root + 1;
         w.magnitude = root[CW-1:0];
         if (x == 0) begin
            turn = (y < 0) ? TURN_3QUARTER : TURN_QUARTER;
         end else if (y == 0) begin
            turn = (x < 0) ? TURN_HALF : TURN_ZERO;
         end else begin
            turn = TURN_ZERO;
            if (x < 0) begin
               x = -x;
               y = -y;
               turn = TURN_HALF;
            end
            x = x * (longint'(1) << GUARD);
            y = y * (longint'(1) << GUARD);
            for (int i = 0; i < NUM_STAGES; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y >= 0) begin
                  x = x + dx;
                  y = y - dy;
                  turn = turn + ATAN_STEP[i];
               end else begin
                  x = x - dx;
                  y = y + dy;
                  turn = turn - ATAN_STEP[i];
               end
            end
         end
         rounded = turn + (32'h1 << (31 - AW));
         w.angle = rounded[ACC_WIDTH-1 -: AW];
         return w;
      endfunction

      function void note_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
         expected_q.push_back(predict_polar(x, y));
      endfunction

      function void check_result(logic [CW-1:0] magnitude, logic [AW-1:0] angle);
         polar_word_type w;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, got magnitude %0d angle %0d",
                     $time, magnitude, angle);
            return;
         end
         w = expected_q.pop_front();
         if (magnitude !== w.magnitude) begin
            mismatches++;
            $display("%0t: magnitude mismatch, expected %0d, got %0d",
                     $time, w.magnitude, magnitude);
         end
         if (angle !== w.angle) begin
            mismatches++;
            $display("%0t: angle mismatch, expected %0d, got %0d", $time, w.angle, angle);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_x_coord = '0;
   logic signed [CW-1:0] req_y_coord = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CW-1:0] rsp_magnitude;
   logic [AW-1:0] rsp_angle;

   int unsigned req_idle_pct = 13;
   int unsigned rsp_stall_pct = 60;
   int unsigned points_sent = 0;

   polar_scoreboard board = new;

   cartesian_to_polar u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle     (rsp_angle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_magnitude, rsp_angle);
   end

   // entered and left just after a falling edge
   task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         req_x_coord = CW'($urandom());
         req_y_coord = CW'($urandom());
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_x_coord = x;
      req_y_coord = y;
      do @(posedge clock); while (!req_ready);
      board.note_point(x, y);
      points_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   function automatic void pick_point(output logic signed [CW-1:0] x,
                                      output logic signed [CW-1:0] y);
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         x = CW'($urandom());
         y = CW'($urandom());
      end else if (kind < 70) begin
         x = CW'($urandom_range(0, 31) - 16);
         y = CW'($urandom_range(0, 31) - 16);
      end else if (kind < 80) begin
         x = CW'($urandom());
         y = CW'($urandom());
         if ($urandom_range(0, 1)) x = '0;
         else y = '0;
      end else if (kind < 90) begin
         x = CORNERS[$urandom_range(0, 6)];
         y = CORNERS[$urandom_range(0, 6)];
      end else begin
         // near the diagonals
         x = CW'($urandom());
         y = $urandom_range(0, 1) ? x : -x;
         y = CW'(y + $urandom_range(0, 4) - 2);
      end
   endfunction

   initial begin
      logic signed [CW-1:0] px, py;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (DIRECTED_X[i]) send_point(DIRECTED_X[i], DIRECTED_Y[i]);
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            req_idle_pct = 60;
            rsp_stall_pct = 13;
         end else if (phase == 2) begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         repeat (RANDOM_PER_PHASE) begin
            pick_point(px, py);
            send_point(px, py);
         end
         // hold the input back until the pipeline is empty
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("sent %0d points (%0d directed, axes, corners, diagonals and random)",
               points_sent, $size(DIRECTED_X));
      $display("checked %0d result words under three idle and stall mixes, %0d mismatches",
               board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d words outstanding", board.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule
